// ===== rtl/uue_pkg.sv =====
`default_nettype none

package uue_pkg;

  // Operation codes carried by an input beat.
  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  // Kind of work handed from the front to the back.
  typedef enum logic {
    JOB_HDR = 1'b0,
    JOB_GRP = 1'b1
  } job_kind_t;

  localparam logic [7:0] SYM_ZERO  = 8'd96;
  localparam logic [7:0] SYM_BIAS  = 8'd32;
  localparam int         HDR_CHARS = 8;
  localparam int         GRP_CHARS = 4;

  typedef struct packed {
    logic        operation;
    logic [31:0] message_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_of_message;
  } out_item_t;

  // One job: a header (32-bit length, eight hex digits) or a group
  // (three bytes left-aligned in the word, four symbols).
  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] word;
    logic        last;
  } job_t;

  // Upper-case ASCII hex digit of a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = 8'h30 + {4'd0, v};
    end else begin
      c = 8'h41 + {4'd0, v} - 8'd10;
    end
    return c;
  endfunction

  // Uuencode symbol of a 6-bit value; zero maps to the backquote.
  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] c;
    if (v == 6'd0) begin
      c = SYM_ZERO;
    end else begin
      c = SYM_BIAS + {2'd0, v};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/uue_front.sv =====
`default_nettype none

module uue_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire uue_pkg::in_item_t in_item,
  input  wire logic            q_ready,
  output logic                 q_push,
  output uue_pkg::job_t        q_job
);
  import uue_pkg::*;

  logic        active_r, active_nxt;
  logic [31:0] exp_len_r, exp_len_nxt;
  logic [31:0] taken_r, taken_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [7:0]  grp0_r, grp1_r;
  logic        accept;
  logic [31:0] taken_inc;
  logic        done;

  // A beat is taken whenever the queue has room, even if it is dropped.
  assign in_ready  = q_ready;
  assign accept    = in_valid && in_ready;
  assign taken_inc = taken_r + 32'd1;
  assign done      = (taken_inc == exp_len_r);

  // Classify the beat and build the job it causes.
  always_comb begin
    active_nxt  = active_r;
    exp_len_nxt = exp_len_r;
    taken_nxt   = taken_r;
    fill_nxt    = fill_r;
    q_push      = 1'b0;
    q_job.kind  = JOB_HDR;
    q_job.word  = in_item.message_length;
    q_job.last  = 1'b0;
    if (accept) begin
      if (op_t'(in_item.operation) == OP_START) begin
        q_push      = 1'b1;
        q_job.last  = (in_item.message_length == 32'd0);
        exp_len_nxt = in_item.message_length;
        taken_nxt   = 32'd0;
        fill_nxt    = 2'd0;
        active_nxt  = (in_item.message_length != 32'd0);
      end else if (active_r) begin
        taken_nxt = taken_inc;
        if (fill_r < 2'd2 && !done) begin
          fill_nxt = fill_r + 2'd1;
        end else begin
          q_push     = 1'b1;
          q_job.kind = JOB_GRP;
          q_job.last = done;
          case (fill_r)
            2'd0:    q_job.word = {in_item.data_byte, 24'd0};
            2'd1:    q_job.word = {grp0_r, in_item.data_byte, 16'd0};
            default: q_job.word = {grp0_r, grp1_r, in_item.data_byte, 8'd0};
          endcase
          fill_nxt = 2'd0;
          if (done) begin
            active_nxt = 1'b0;
          end
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      exp_len_r <= 32'd0;
      taken_r   <= 32'd0;
      fill_r    <= 2'd0;
    end else begin
      active_r  <= active_nxt;
      exp_len_r <= exp_len_nxt;
      taken_r   <= taken_nxt;
      fill_r    <= fill_nxt;
    end
  end

  // Held bytes of the current group.
  always_ff @(posedge clk) begin
    if (accept && op_t'(in_item.operation) == OP_DATA && active_r
        && fill_r < 2'd2 && !done) begin
      if (fill_r == 2'd0) begin
        grp0_r <= in_item.data_byte;
      end else begin
        grp1_r <= in_item.data_byte;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uue_fifo.sv =====
`default_nettype none

module uue_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire uue_pkg::job_t push_job,
  output logic               not_full,
  input  wire logic          pop,
  output logic               not_empty,
  output uue_pkg::job_t      head_job
);
  import uue_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign not_full  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_job  = mem_r[rd_ptr_r];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uue_back.sv =====
`default_nettype none

module uue_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire uue_pkg::job_t q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output uue_pkg::out_item_t out_item
);
  import uue_pkg::*;

  logic      busy_r, busy_nxt;
  job_t      cur_r, cur_nxt;
  logic [2:0] left_r, left_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      advance;
  logic      job_end;

  assign advance   = busy_r && (!out_valid_r || out_ready);
  assign job_end   = advance && (left_r == 3'd0);
  assign q_pop     = q_valid && (!busy_r || job_end);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Emit one character per cycle from the current job while the output is not stalled, shifting its word.
  always_comb begin
    busy_nxt      = busy_r;
    cur_nxt       = cur_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_item_nxt.last_of_message = cur_r.last && (left_r == 3'd0);
      if (cur_r.kind == JOB_HDR) begin
        out_item_nxt.character = hex_char(cur_r.word[31:28]);
        cur_nxt.word = {cur_r.word[27:0], 4'd0};
      end else begin
        out_item_nxt.character = sym_char(cur_r.word[31:26]);
        cur_nxt.word = {cur_r.word[25:0], 6'd0};
      end
      left_nxt = left_r - 3'd1;
      if (left_r == 3'd0) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      cur_nxt  = q_job;
      left_nxt = (q_job.kind == JOB_HDR) ? 3'(HDR_CHARS - 1) : 3'(GRP_CHARS - 1);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      left_r      <= 3'd0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      left_r      <= left_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/uuencode_length_prefixed_encoder_core.sv =====
// Path: a job passes through the job queue, the back end's job register and its
// output register before its first character appears when the back end is idle.
// Throughput: the character back end emits one character per cycle while out_ready
// does not stall it; a start beat yields eight characters and a group of up to
// three data bytes four; a two-entry job queue lets the front take beats meanwhile.
// Reset: synchronous active-low rst_n clears the message state, queue and output.
`default_nettype none

module uuencode_length_prefixed_encoder_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire uue_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output uue_pkg::out_item_t      out_item
);
  import uue_pkg::*;

  logic q_push, q_not_full, q_pop, q_not_empty;
  job_t push_job, head_job;

  // Front: takes beats, tracks the message and builds jobs.
  uue_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_ready  (q_not_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // Job queue between the two halves.
  uue_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // Back: turns jobs into output characters.
  uue_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
